// ===== sv/pgs_pkg.sv =====
`timescale 1ns / 1ps

package pgs_pkg;

  // Width of the shared serial datapath: the largest operand is the
  // accel numerator, mu * |d| shifted up by 112 (201 bits).
  localparam int ARITH_W = 208;
  localparam int CNT_W   = 8;

  localparam logic [CNT_W-1:0] MUL_STEPS  = CNT_W'(64);
  localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(ARITH_W);
  localparam logic [CNT_W-1:0] SQRT_STEPS = CNT_W'(ARITH_W / 2);

  localparam int R2_W = 84;
  localparam int R_W  = 58;

  localparam logic [62:0] POT_MAX = {63{1'b1}};
  localparam logic signed [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] ACC_MIN = {1'b1, {63{1'b0}}};

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } arith_op_t;

  typedef enum logic [3:0] {
    TS_IDLE,
    TS_SQX,
    TS_SQY,
    TS_SQZ,
    TS_ROOT,
    TS_RSQ,
    TS_RCUBE,
    TS_POT,
    TS_NUMX,
    TS_DIVX,
    TS_NUMY,
    TS_DIVY,
    TS_NUMZ,
    TS_DIVZ
  } term_st_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_START,
    ST_WAIT,
    ST_DONE
  } pgs_st_t;

  typedef struct packed {
    logic               mode;
    logic [9:0]         entry_index;
    logic signed [39:0] pos_x;
    logic signed [39:0] pos_y;
    logic signed [39:0] pos_z;
    logic [47:0]        grav_param;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] accel_x;
    logic signed [63:0] accel_y;
    logic signed [63:0] accel_z;
    logic [62:0]        potential;
    logic               singular;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [39:0] px;
    logic signed [39:0] py;
    logic signed [39:0] pz;
    logic [47:0]        mu;
  } mass_t;

  typedef struct packed {
    logic [62:0]        pot;
    logic signed [63:0] ax;
    logic signed [63:0] ay;
    logic signed [63:0] az;
    logic               sat;
    logic               singular;
  } term_t;

  typedef struct packed {
    logic signed [63:0] val;
    logic               sat;
  } axis_t;

  // Turn an unsigned quotient into a signed accel term of opposite sign to d.
  function automatic axis_t axis_term(input logic [ARITH_W-1:0] q, input logic d_neg);
    axis_t       r;
    logic        big;
    logic [63:0] m;
    big   = |q[ARITH_W-1:64];
    m     = q[63:0];
    r.sat = 1'b0;
    r.val = '0;
    if (!big && m == 64'd0) begin
      r.val = '0;
    end else if (!d_neg) begin
      if (big || m > 64'h8000_0000_0000_0000) begin
        r.sat = 1'b1;
        r.val = ACC_MIN;
      end else begin
        r.val = $signed(64'd0 - m);
      end
    end else begin
      if (big || m[63]) begin
        r.sat = 1'b1;
        r.val = ACC_MAX;
      end else begin
        r.val = $signed(m);
      end
    end
    return r;
  endfunction

  // Saturating signed 64-bit add.
  function automatic axis_t sat_add(input logic signed [63:0] s, input logic signed [63:0] t);
    axis_t       r;
    logic [64:0] sum;
    sum   = {s[63], s} + {t[63], t};
    r.sat = (sum[64] != sum[63]);
    if (r.sat) begin
      r.val = sum[64] ? ACC_MIN : ACC_MAX;
    end else begin
      r.val = $signed(sum[63:0]);
    end
    return r;
  endfunction

endpackage

// ===== sv/pgs_table.sv =====
`timescale 1ns / 1ps

module pgs_table #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  pgs_pkg::mass_t  wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output pgs_pkg::mass_t  rd_data
);
  import pgs_pkg::*;

  mass_t mem_r [DEPTH];
  mass_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/pgs_arith.sv =====
`timescale 1ns / 1ps

module pgs_arith (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  pgs_pkg::arith_op_t           op,
  input  logic [pgs_pkg::ARITH_W-1:0]  a_in,
  input  logic [pgs_pkg::ARITH_W-1:0]  b_in,
  output logic                         done,
  output logic [pgs_pkg::ARITH_W-1:0]  res
);
  import pgs_pkg::*;

  localparam int W = ARITH_W;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  arith_op_t        op_r, op_nxt;
  logic [W-1:0]     a_r, a_nxt;
  logic [W-1:0]     b_r, b_nxt;
  logic [W-1:0]     acc_r, acc_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [W-1:0] rem_sh;
  logic [W-1:0] sub_y;
  logic [W-1:0] sub_d;
  logic         ge;

  // One shared compare and subtract serves both divide and root steps.
  always_comb begin
    if (op_r == OP_SQRT) begin
      rem_sh = {rem_r[W-3:0], a_r[W-1:W-2]};
      sub_y  = {acc_r[W-3:0], 2'b01};
    end else begin
      rem_sh = {rem_r[W-2:0], a_r[W-1]};
      sub_y  = b_r;
    end
    ge    = (rem_sh >= sub_y);
    sub_d = rem_sh - sub_y;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      op_nxt   = op;
      a_nxt    = a_in;
      b_nxt    = b_in;
      acc_nxt  = '0;
      rem_nxt  = '0;
      case (op)
        OP_MUL:  cnt_nxt = MUL_STEPS;
        OP_DIV:  cnt_nxt = DIV_STEPS;
        OP_SQRT: cnt_nxt = SQRT_STEPS;
        default: cnt_nxt = MUL_STEPS;
      endcase
    end else if (busy_r) begin
      case (op_r)
        OP_MUL: begin
          if (b_r[0]) begin
            acc_nxt = acc_r + a_r;
          end
          a_nxt = {a_r[W-2:0], 1'b0};
          b_nxt = {1'b0, b_r[W-1:1]};
        end
        OP_DIV: begin
          rem_nxt = ge ? sub_d : rem_sh;
          acc_nxt = {acc_r[W-2:0], ge};
          a_nxt   = {a_r[W-2:0], 1'b0};
        end
        OP_SQRT: begin
          rem_nxt = ge ? sub_d : rem_sh;
          acc_nxt = {acc_r[W-2:0], ge};
          a_nxt   = {a_r[W-3:0], 2'b00};
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= OP_MUL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign res  = acc_r;

endmodule

// ===== sv/pgs_term.sv =====
`timescale 1ns / 1ps

module pgs_term (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  pgs_pkg::mass_t      entry,
  input  logic signed [39:0]  qx,
  input  logic signed [39:0]  qy,
  input  logic signed [39:0]  qz,
  output logic                done,
  output pgs_pkg::term_t      term
);
  import pgs_pkg::*;

  localparam int W = ARITH_W;

  term_st_t           st_r, st_nxt;
  logic signed [40:0] dx_r, dx_nxt;
  logic signed [40:0] dy_r, dy_nxt;
  logic signed [40:0] dz_r, dz_nxt;
  logic [47:0]        mu_r, mu_nxt;
  logic [R2_W-1:0]    r2_r, r2_nxt;
  logic [R_W-1:0]     rt_r, rt_nxt;
  logic [W-1:0]       r3_r, r3_nxt;
  term_t              term_r, term_nxt;
  logic               done_r, done_nxt;

  logic               go;
  arith_op_t          go_op;
  logic [W-1:0]       go_a;
  logic [W-1:0]       go_b;
  logic               ar_done;
  logic [W-1:0]       ar_res;

  logic signed [40:0] dx_in;
  logic [40:0]        mx, my, mz, mx_in;
  logic [R2_W-1:0]    r2_sum;
  axis_t              ax_t, ay_t, az_t;

  pgs_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go),
    .op    (go_op),
    .a_in  (go_a),
    .b_in  (go_b),
    .done  (ar_done),
    .res   (ar_res)
  );

  always_comb begin
    dx_in  = {qx[39], qx} - {entry.px[39], entry.px};
    mx_in  = dx_in[40] ? 41'(-dx_in) : 41'(dx_in);
    mx     = dx_r[40] ? 41'(-dx_r) : 41'(dx_r);
    my     = dy_r[40] ? 41'(-dy_r) : 41'(dy_r);
    mz     = dz_r[40] ? 41'(-dz_r) : 41'(dz_r);
    r2_sum = r2_r + ar_res[R2_W-1:0];
    ax_t   = axis_term(ar_res, dx_r[40]);
    ay_t   = axis_term(ar_res, dy_r[40]);
    az_t   = axis_term(ar_res, dz_r[40]);

    st_nxt   = st_r;
    dx_nxt   = dx_r;
    dy_nxt   = dy_r;
    dz_nxt   = dz_r;
    mu_nxt   = mu_r;
    r2_nxt   = r2_r;
    rt_nxt   = rt_r;
    r3_nxt   = r3_r;
    term_nxt = term_r;
    done_nxt = 1'b0;
    go       = 1'b0;
    go_op    = OP_MUL;
    go_a     = '0;
    go_b     = '0;

    case (st_r)
      TS_IDLE: begin
        if (start) begin
          dx_nxt   = dx_in;
          dy_nxt   = {qy[39], qy} - {entry.py[39], entry.py};
          dz_nxt   = {qz[39], qz} - {entry.pz[39], entry.pz};
          mu_nxt   = entry.mu;
          term_nxt = '0;
          go       = 1'b1;
          go_a     = W'(mx_in);
          go_b     = W'(mx_in);
          st_nxt   = TS_SQX;
        end
      end
      TS_SQX: begin
        if (ar_done) begin
          r2_nxt = ar_res[R2_W-1:0];
          go     = 1'b1;
          go_a   = W'(my);
          go_b   = W'(my);
          st_nxt = TS_SQY;
        end
      end
      TS_SQY: begin
        if (ar_done) begin
          r2_nxt = r2_sum;
          go     = 1'b1;
          go_a   = W'(mz);
          go_b   = W'(mz);
          st_nxt = TS_SQZ;
        end
      end
      TS_SQZ: begin
        if (ar_done) begin
          if (r2_sum == '0) begin
            // Mass sits on the query point: skip it.
            term_nxt.singular = 1'b1;
            done_nxt          = 1'b1;
            st_nxt            = TS_IDLE;
          end else begin
            go     = 1'b1;
            go_op  = OP_SQRT;
            go_a   = W'({r2_sum, 32'd0});
            st_nxt = TS_ROOT;
          end
        end
      end
      TS_ROOT: begin
        if (ar_done) begin
          rt_nxt = ar_res[R_W-1:0];
          go     = 1'b1;
          go_a   = W'(ar_res[R_W-1:0]);
          go_b   = W'(ar_res[R_W-1:0]);
          st_nxt = TS_RSQ;
        end
      end
      TS_RSQ: begin
        if (ar_done) begin
          go     = 1'b1;
          go_a   = ar_res;
          go_b   = W'(rt_r);
          st_nxt = TS_RCUBE;
        end
      end
      TS_RCUBE: begin
        if (ar_done) begin
          r3_nxt = ar_res;
          go     = 1'b1;
          go_op  = OP_DIV;
          go_a   = W'({mu_r, 48'd0});
          go_b   = W'(rt_r);
          st_nxt = TS_POT;
        end
      end
      TS_POT: begin
        if (ar_done) begin
          if (|ar_res[W-1:63]) begin
            term_nxt.pot = POT_MAX;
            term_nxt.sat = 1'b1;
          end else begin
            term_nxt.pot = ar_res[62:0];
          end
          go     = 1'b1;
          go_a   = W'(mu_r);
          go_b   = W'(mx);
          st_nxt = TS_NUMX;
        end
      end
      TS_NUMX, TS_NUMY, TS_NUMZ: begin
        if (ar_done) begin
          go    = 1'b1;
          go_op = OP_DIV;
          go_a  = W'({ar_res[88:0], 112'd0});
          go_b  = r3_r;
          case (st_r)
            TS_NUMX: st_nxt = TS_DIVX;
            TS_NUMY: st_nxt = TS_DIVY;
            default: st_nxt = TS_DIVZ;
          endcase
        end
      end
      TS_DIVX: begin
        if (ar_done) begin
          term_nxt.ax  = ax_t.val;
          term_nxt.sat = term_r.sat | ax_t.sat;
          go           = 1'b1;
          go_a         = W'(mu_r);
          go_b         = W'(my);
          st_nxt       = TS_NUMY;
        end
      end
      TS_DIVY: begin
        if (ar_done) begin
          term_nxt.ay  = ay_t.val;
          term_nxt.sat = term_r.sat | ay_t.sat;
          go           = 1'b1;
          go_a         = W'(mu_r);
          go_b         = W'(mz);
          st_nxt       = TS_NUMZ;
        end
      end
      TS_DIVZ: begin
        if (ar_done) begin
          term_nxt.az  = az_t.val;
          term_nxt.sat = term_r.sat | az_t.sat;
          done_nxt     = 1'b1;
          st_nxt       = TS_IDLE;
        end
      end
      default: begin
        st_nxt = TS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= TS_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    dz_r   <= dz_nxt;
    mu_r   <= mu_nxt;
    r2_r   <= r2_nxt;
    rt_r   <= rt_nxt;
    r3_r   <= r3_nxt;
    term_r <= term_nxt;
  end

  assign done = done_r;
  assign term = term_r;

endmodule

// ===== sv/point_mass_gravity_sum.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall    in_item_t (load or query item)
// out_      output     out_valid / out_stall  out_item_t (one per query)
// cfg_      input      cfg_wr_en              cfg_wr_data = mass_count
//
// A load item is written to the table as it is accepted. A query walks the
// included masses in turn: a table read, then a term on the single serial
// arithmetic unit (eight 64-step multiplies, one 104-step root, four
// 208-step divides); a mass at zero distance stops after the three squares.
// Synchronous active-low reset; the table holds no reset value.
// A finished result waits in the output register while out_stall is high;
// the next query is still taken and computed, but its result holds the
// block, and with it the input, until the register frees.

module point_mass_gravity_sum #(
  parameter int MAX_MASSES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pgs_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pgs_pkg::out_item_t  out_data,
  input  logic                cfg_wr_en,
  input  logic [10:0]         cfg_wr_data
);
  import pgs_pkg::*;

  localparam int AW = (MAX_MASSES > 1) ? $clog2(MAX_MASSES) : 1;
  localparam int CW = $clog2(MAX_MASSES + 1);

  pgs_st_t            st_r, st_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [10:0]        mass_count_r;
  logic signed [39:0] qx_r, qx_nxt;
  logic signed [39:0] qy_r, qy_nxt;
  logic signed [39:0] qz_r, qz_nxt;
  logic [62:0]        pot_r, pot_nxt;
  logic signed [63:0] ax_r, ax_nxt;
  logic signed [63:0] ay_r, ay_nxt;
  logic signed [63:0] az_r, az_nxt;
  logic               sat_r, sat_nxt;
  logic               sing_r, sing_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               in_acc;
  logic               load_wr;
  logic [CW-1:0]      cnt_eff;
  logic               rd_en;
  mass_t              rd_data;
  mass_t              wr_data;
  logic               term_start;
  logic               term_done;
  term_t              term;
  logic [63:0]        pot_sum;
  axis_t              sx, sy, sz;

  assign in_acc  = in_valid && !in_stall;
  // Drop loads aimed beyond the table.
  assign load_wr = in_acc && (in_data.mode == MODE_LOAD) &&
                   (32'(in_data.entry_index) < MAX_MASSES);
  assign cnt_eff = (32'(mass_count_r) > MAX_MASSES) ? CW'(MAX_MASSES) : CW'(mass_count_r);

  assign wr_data.px = in_data.pos_x;
  assign wr_data.py = in_data.pos_y;
  assign wr_data.pz = in_data.pos_z;
  assign wr_data.mu = in_data.grav_param;

  // Loads only land while idle and reads only run during a query, so the
  // two ports never touch the same entry in the same window.
  pgs_table #(
    .DEPTH (MAX_MASSES),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (load_wr),
    .wr_addr (AW'(in_data.entry_index)),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  pgs_term u_term (
    .clk   (clk),
    .rst_n (rst_n),
    .start (term_start),
    .entry (rd_data),
    .qx    (qx_r),
    .qy    (qy_r),
    .qz    (qz_r),
    .done  (term_done),
    .term  (term)
  );

  // Saturating accumulation of one mass' terms.
  always_comb begin
    pot_sum = {1'b0, pot_r} + {1'b0, term.pot};
    sx      = sat_add(ax_r, term.ax);
    sy      = sat_add(ay_r, term.ay);
    sz      = sat_add(az_r, term.az);
  end

  always_comb begin
    st_nxt        = st_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    qz_nxt        = qz_r;
    pot_nxt       = pot_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    az_nxt        = az_r;
    sat_nxt       = sat_r;
    sing_nxt      = sing_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = (st_r != ST_IDLE);
    rd_en         = 1'b0;
    term_start    = 1'b0;

    case (st_r)
      ST_IDLE: begin
        if (in_acc && in_data.mode == MODE_QUERY) begin
          qx_nxt   = in_data.pos_x;
          qy_nxt   = in_data.pos_y;
          qz_nxt   = in_data.pos_z;
          idx_nxt  = '0;
          cnt_nxt  = cnt_eff;
          pot_nxt  = '0;
          ax_nxt   = '0;
          ay_nxt   = '0;
          az_nxt   = '0;
          sat_nxt  = 1'b0;
          sing_nxt = 1'b0;
          st_nxt   = (cnt_eff == '0) ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        rd_en  = 1'b1;
        st_nxt = ST_START;
      end
      ST_START: begin
        term_start = 1'b1;
        st_nxt     = ST_WAIT;
      end
      ST_WAIT: begin
        if (term_done) begin
          pot_nxt  = pot_sum[63] ? POT_MAX : pot_sum[62:0];
          ax_nxt   = sx.val;
          ay_nxt   = sy.val;
          az_nxt   = sz.val;
          sat_nxt  = sat_r | term.sat | pot_sum[63] | sx.sat | sy.sat | sz.sat;
          sing_nxt = sing_r | term.singular;
          idx_nxt  = idx_r + CW'(1);
          st_nxt   = (idx_r + CW'(1) == cnt_r) ? ST_DONE : ST_READ;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.accel_x   = ax_r;
          out_data_nxt.accel_y   = ay_r;
          out_data_nxt.accel_z   = az_r;
          out_data_nxt.potential = pot_r;
          out_data_nxt.singular  = sing_r;
          out_data_nxt.saturated = sat_r;
          out_valid_nxt          = 1'b1;
          st_nxt                 = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      out_valid_r  <= 1'b0;
      mass_count_r <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        mass_count_r <= cfg_wr_data;
      end
    end
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    qx_r       <= qx_nxt;
    qy_r       <= qy_nxt;
    qz_r       <= qz_nxt;
    pot_r      <= pot_nxt;
    ax_r       <= ax_nxt;
    ay_r       <= ay_nxt;
    az_r       <= az_nxt;
    sat_r      <= sat_nxt;
    sing_r     <= sing_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    term_done |-> st_r == ST_WAIT)
    else $error("term result arrived outside of a wait");

  a_read_then_start: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_READ |=> st_r == ST_START)
    else $error("table read not followed by term start");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_READ |-> idx_r < cnt_r)
    else $error("table read beyond mass count");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r) == ST_DONE)
    else $error("result raised outside of the done step");

endmodule

// ===== tb/sv/point_mass_gravity_sum_tb.sv =====
`timescale 1ns / 1ps

module point_mass_gravity_sum_tb;
  import pgs_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int WIDE_COUNT = 32;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 4000;
  localparam logic signed [39:0] P40_MAX = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] P40_MIN = {1'b1, {39{1'b0}}};
  localparam logic [47:0] MU_MAX = {48{1'b1}};

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_wr_en;
  logic [10:0] cfg_wr_data;

  point_mass_gravity_sum uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Shadow copy of the mass table and count register.
  logic signed [39:0] tbl_x [TABLE_DEPTH];
  logic signed [39:0] tbl_y [TABLE_DEPTH];
  logic signed [39:0] tbl_z [TABLE_DEPTH];
  logic [47:0] tbl_mu [TABLE_DEPTH];
  logic [10:0] shadow_count;

  out_item_t fields_due[$];
  bit term_sat;
  bit quiet;        // no idling on either side
  bit hold_req;
  int hold_left;
  int stall_left;
  int mismatches;
  int fails;
  int loads_sent;
  int queries_sent;
  int results_seen;
  int idle_cycles;

  always #5 clk = ~clk;

  // Integer square root, floor, over the span the distance can take.
  function automatic logic [255:0] isqrt(input logic [255:0] v);
    logic [255:0] res;
    logic [255:0] t;
    res = '0;
    for (int b = 58; b >= 0; b--) begin
      t = res | (256'd1 << b);
      if (t * t <= v) res = t;
    end
    return res;
  endfunction

  function automatic logic [255:0] magnitude(input longint d);
    return d < 0 ? 256'(-d) : 256'(d);
  endfunction

  // One axis of -mu*d/|d|^3, clamped to the signed 64-bit range.
  function automatic longint accel_term(input logic [47:0] mu, input longint d,
                                        input logic [255:0] r3);
    logic [255:0] q;
    logic [63:0] m;
    bit big;
    q = ((256'(mu) * magnitude(d)) << 112) / r3;
    big = |q[255:64];
    m = q[63:0];
    if (q == 0) return 0;
    if (d > 0) begin
      if (big || m > 64'h8000_0000_0000_0000) begin
        term_sat = 1;
        return ACC_MIN;
      end
      return longint'(64'd0 - m);
    end
    if (big || m[63]) begin
      term_sat = 1;
      return ACC_MAX;
    end
    return longint'(m);
  endfunction

  function automatic longint sum_clamped(input longint s, input longint t);
    logic signed [64:0] sum;
    sum = 65'(s) + 65'(t);
    if (sum > 65'(ACC_MAX)) begin
      term_sat = 1;
      return ACC_MAX;
    end
    if (sum < 65'(ACC_MIN)) begin
      term_sat = 1;
      return ACC_MIN;
    end
    return longint'(sum[63:0]);
  endfunction

  // Summed field and potential at the query position over the included masses.
  function automatic out_item_t field_at(input in_item_t q);
    out_item_t r;
    longint acc [3];
    longint d [3];
    logic [62:0] pot;
    logic [62:0] pterm;
    logic [255:0] r2;
    logic [255:0] rad;
    logic [255:0] r3;
    logic [255:0] quo;
    bit sing;
    int n;
    acc = '{0, 0, 0};
    pot = '0;
    sing = 0;
    term_sat = 0;
    n = shadow_count > TABLE_DEPTH ? TABLE_DEPTH : int'(shadow_count);
    for (int i = 0; i < n; i++) begin
      d[0] = longint'(q.pos_x) - longint'(tbl_x[i]);
      d[1] = longint'(q.pos_y) - longint'(tbl_y[i]);
      d[2] = longint'(q.pos_z) - longint'(tbl_z[i]);
      r2 = magnitude(d[0]) * magnitude(d[0]) + magnitude(d[1]) * magnitude(d[1])
         + magnitude(d[2]) * magnitude(d[2]);
      if (r2 == 0) begin
        sing = 1;
        continue;
      end
      rad = isqrt(r2 << 32);
      r3 = rad * rad * rad;
      quo = (256'(tbl_mu[i]) << 48) / rad;
      if (|quo[255:63]) begin
        term_sat = 1;
        pterm = POT_MAX;
      end else begin
        pterm = quo[62:0];
      end
      if (pterm > POT_MAX - pot) begin
        term_sat = 1;
        pot = POT_MAX;
      end else begin
        pot = pot + pterm;
      end
      for (int k = 0; k < 3; k++) begin
        acc[k] = sum_clamped(acc[k], accel_term(tbl_mu[i], d[k], r3));
      end
    end
    r.accel_x = acc[0];
    r.accel_y = acc[1];
    r.accel_z = acc[2];
    r.potential = pot;
    r.singular = sing;
    r.saturated = term_sat;
    return r;
  endfunction

  // Apply an accepted item to the shadow table or queue its expected field.
  function automatic void absorb_item(input in_item_t it);
    if (it.mode == MODE_LOAD) begin
      tbl_x[it.entry_index] = it.pos_x;
      tbl_y[it.entry_index] = it.pos_y;
      tbl_z[it.entry_index] = it.pos_z;
      tbl_mu[it.entry_index] = it.grav_param;
      loads_sent++;
    end else begin
      fields_due.push_back(field_at(it));
      queries_sent++;
    end
  endfunction

  // Offer one item after a random gap; return once it is accepted.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    absorb_item(it);
  endtask

  function automatic in_item_t make_load(input int idx, input logic signed [39:0] x,
                                         input logic signed [39:0] y,
                                         input logic signed [39:0] z, input logic [47:0] mu);
    in_item_t it;
    it.mode = MODE_LOAD;
    it.entry_index = 10'(idx);
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    it.grav_param = mu;
    return it;
  endfunction

  // Query items still carry random index and mu bits, which the block ignores.
  function automatic in_item_t make_query(input logic signed [39:0] x,
                                          input logic signed [39:0] y,
                                          input logic signed [39:0] z);
    in_item_t it;
    it = make_load($urandom_range(0, TABLE_DEPTH - 1), x, y, z, 48'({$urandom, $urandom}));
    it.mode = MODE_QUERY;
    return it;
  endfunction

  // Mostly near the origin so that terms are neither vanishing nor clamped.
  function automatic logic signed [39:0] rand_pos();
    case ($urandom_range(0, 3))
      0: return 40'({$urandom, $urandom});
      1: return 40'($signed($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000);
      default: return 40'($signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000);
    endcase
  endfunction

  function automatic logic [47:0] rand_mu();
    case ($urandom_range(0, 3))
      0: return 48'({$urandom, $urandom});
      1: return 48'($urandom_range(0, 32'hFFFF));
      default: return 48'($urandom) << $urandom_range(0, 16);
    endcase
  endfunction

  // Let every pending field arrive, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (fields_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_mass_count(input int value);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= 11'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_count = 11'(value);
    @(posedge clk);
  endtask

  // Reset leaves the count at zero: a query sums nothing.
  task automatic test_empty_sum();
    send_item(make_query(P40_MAX, P40_MIN, 40'sd0));
    send_item(make_query(rand_pos(), rand_pos(), rand_pos()));
  endtask

  // Corner positions, extreme mu, zero distance and clamping sums.
  task automatic test_corners();
    send_item(make_load(0, 40'sd0, 40'sd0, 40'sd0, 48'h1_0000));
    send_item(make_load(1, P40_MAX, P40_MAX, P40_MAX, MU_MAX));
    send_item(make_load(2, P40_MIN, P40_MIN, P40_MIN, MU_MAX));
    send_item(make_load(3, 40'sd1, 40'sd0, 40'sd0, MU_MAX));
    for (int i = 4; i < 8; i++) begin
      send_item(make_load(i, rand_pos(), rand_pos(), rand_pos(), rand_mu()));
    end
    set_mass_count(1);
    send_item(make_query(40'sd0, 40'sd0, 40'sd0));
    send_item(make_query(40'sh1_0000, 40'sd0, 40'sd0));
    send_item(make_query(-40'sh1_0000, 40'sh1_0000, -40'sh1_0000));
    set_mass_count(4);
    send_item(make_query(40'sd0, 40'sd0, 40'sd0));
    send_item(make_query(P40_MAX, P40_MAX, P40_MAX));
    send_item(make_query(P40_MIN, P40_MIN, P40_MIN));
    send_item(make_query(40'sd2, 40'sd0, 40'sd0));
    set_mass_count(8);
    send_item(make_query(rand_pos(), rand_pos(), rand_pos()));
  endtask

  // Random loads and queries over several count settings.
  task automatic test_random_mix();
    int idx;
    for (int ph = 0; ph < 6; ph++) begin
      set_mass_count(ph == 5 ? 0 : $urandom_range(1, 4));
      quiet = (ph == 2);
      for (int k = 0; k < 85; k++) begin
        if ($urandom_range(0, 99) < 18) begin
          if ($urandom_range(0, 5) == 0 && shadow_count != 0) begin
            // sit exactly on an included mass
            idx = $urandom_range(0, int'(shadow_count) - 1);
            send_item(make_query(tbl_x[idx], tbl_y[idx], tbl_z[idx]));
          end else begin
            send_item(make_query(rand_pos(), rand_pos(), rand_pos()));
          end
        end else begin
          idx = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, TABLE_DEPTH - 1);
          send_item(make_load(idx, rand_pos(), rand_pos(), rand_pos(), rand_mu()));
        end
      end
      quiet = 0;
    end
  endtask

  // Hold the result side off while queries keep coming, so the input stalls.
  task automatic test_backpressure();
    set_mass_count(1);
    hold_req = 1;
    quiet = 1;
    for (int k = 0; k < 4; k++) send_item(make_query(rand_pos(), rand_pos(), rand_pos()));
    send_item(make_load(5, rand_pos(), rand_pos(), rand_pos(), rand_mu()));
    quiet = 0;
  endtask

  // Pause the sender until every field is back before each query.
  task automatic test_sender_pause();
    set_mass_count(2);
    for (int k = 0; k < 3; k++) begin
      send_item(make_query(rand_pos(), rand_pos(), rand_pos()));
      drain();
    end
  endtask

  // Fill the low entries back to back and sum all of them in one query.
  task automatic test_wide_table();
    quiet = 1;
    for (int i = 0; i < WIDE_COUNT; i++) begin
      send_item(make_load(i, rand_pos(), rand_pos(), rand_pos(), rand_mu()));
    end
    quiet = 0;
    set_mass_count(WIDE_COUNT);
    send_item(make_query(rand_pos(), rand_pos(), rand_pos()));
  endtask

  // Result side: draw a stall before each item, check each accepted item.
  always @(posedge clk) begin
    out_item_t want;
    if (out_valid && !out_stall) begin
      results_seen++;
      if (fields_due.size() == 0) begin
        fails++;
        if (mismatches++ < 10) $display("unexpected result item %h", out_data);
      end else begin
        want = fields_due.pop_front();
        if (out_data.accel_x !== want.accel_x || out_data.accel_y !== want.accel_y ||
            out_data.accel_z !== want.accel_z || out_data.potential !== want.potential ||
            out_data.singular !== want.singular || out_data.saturated !== want.saturated) begin
          fails++;
          if (mismatches++ < 10) begin
            $display("field mismatch: ax %h/%h ay %h/%h az %h/%h", want.accel_x,
                     out_data.accel_x, want.accel_y, out_data.accel_y, want.accel_z,
                     out_data.accel_z);
            $display("  pot %h/%h sing %b/%b sat %b/%b (expected/actual)", want.potential,
                     out_data.potential, want.singular, out_data.singular, want.saturated,
                     out_data.saturated);
          end
        end
      end
      stall_left = quiet ? 0 : $urandom_range(0, 9);
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= IDLE_LIMIT) begin
      $display("point_mass_gravity_sum_tb NOT OK");
      $finish;
    end
  end

  initial begin
    clk = 0;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    cfg_wr_en = 0;
    cfg_wr_data = '0;
    shadow_count = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_sum();
    test_corners();
    test_random_mix();
    test_backpressure();
    test_sender_pause();
    test_wide_table();
    drain();
    if (fields_due.size() != 0) fails++;
    $display("covered %0d loads and %0d queries, %0d result items checked", loads_sent,
             queries_sent, results_seen);
    $display("counts 0..8 and a 32-entry sum, with random idling, a long hold and pauses");
    if (fails == 0) begin
      $display("point_mass_gravity_sum_tb OK");
    end else begin
      $display("point_mass_gravity_sum_tb NOT OK");
    end
    $finish;
  end

endmodule
